/* hw/rtl/icy_deint_pkg.sv */
// ----------------------------------------------------------------------------
// icy_deint_pkg
// Shared widths, byte kind codes, configuration port geometry and the
// classifier result type for the ICY metadata deinterleaver.
// ----------------------------------------------------------------------------
`default_nettype none

package icy_deint_pkg;

  // Stream byte and field widths.
  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int CNT_W  = 16;
  localparam int IDX_W  = 12;

  // A length byte counts blocks of sixteen metadata bytes.
  localparam int BLOCK_SHIFT = 4;

  // Default size of the metadata store in bytes.
  localparam int META_STORE_BYTES_DEF = 4096;

  // Byte kind codes carried on the result channel.
  localparam logic [KIND_W-1:0] KIND_AUDIO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LEN   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_META  = 2'd2;

  // Configuration port geometry and register indexes.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_META_INTERVAL = 1'b0;

  // Classification of one byte, handed from the parser to the datapath.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              blk_end;
    logic [IDX_W-1:0]  idx;
  } cls_t;

endpackage

`default_nettype wire

/* hw/rtl/icy_deint_ram.sv */
// ----------------------------------------------------------------------------
// icy_deint_ram
// Generic single-write, single-read RAM with a registered read port. The
// read data holds while no read is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module icy_deint_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* hw/rtl/icy_deint_ctrl.sv */
// ----------------------------------------------------------------------------
// icy_deint_ctrl
// Stream parser: tracks the audio and metadata phases, counts audio bytes
// and metadata bytes, and classifies each incoming byte.
// ----------------------------------------------------------------------------
`default_nettype none

module icy_deint_ctrl
  import icy_deint_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [BYTE_W-1:0] data,
  input  wire logic [CNT_W-1:0]  meta_interval,
  output cls_t                   cls
);

  localparam logic PH_AUDIO = 1'b0;
  localparam logic PH_META  = 1'b1;

  logic             phase_r, phase_nxt;
  logic [CNT_W-1:0] audio_count_r, audio_count_nxt;
  logic [IDX_W-1:0] meta_left_r, meta_left_nxt;
  logic [IDX_W-1:0] meta_index_r, meta_index_nxt;

  // Classify the current byte and work out the next parser state.
  always_comb begin
    phase_nxt       = phase_r;
    audio_count_nxt = audio_count_r;
    meta_left_nxt   = meta_left_r;
    meta_index_nxt  = meta_index_r;
    cls.kind        = KIND_AUDIO;
    cls.blk_end     = 1'b0;
    cls.idx         = meta_index_r;

    case (phase_r)
      PH_META: begin
        cls.kind       = KIND_META;
        meta_index_nxt = meta_index_r + IDX_W'(1);
        if (meta_left_r <= IDX_W'(1)) begin
          cls.blk_end   = 1'b1;
          meta_left_nxt = '0;
          phase_nxt     = PH_AUDIO;
        end else begin
          meta_left_nxt = meta_left_r - IDX_W'(1);
        end
      end
      default: begin
        if (meta_interval != '0 && audio_count_r >= meta_interval) begin
          // Length byte: sets up a block of sixteen-byte units.
          cls.kind        = KIND_LEN;
          audio_count_nxt = '0;
          meta_index_nxt  = '0;
          meta_left_nxt   = IDX_W'({data, {BLOCK_SHIFT{1'b0}}});
          if (data == '0) begin
            cls.blk_end = 1'b1;
            phase_nxt   = PH_AUDIO;
          end else begin
            phase_nxt   = PH_META;
          end
        end else begin
          phase_nxt = PH_AUDIO;
          if (meta_interval != '0) begin
            audio_count_nxt = audio_count_r + CNT_W'(1);
          end
        end
      end
    endcase
  end

  // Parser state advances once per transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_AUDIO;
      audio_count_r <= '0;
      meta_left_r   <= '0;
      meta_index_r  <= '0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      audio_count_r <= audio_count_nxt;
      meta_left_r   <= meta_left_nxt;
      meta_index_r  <= meta_index_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/icy_metadata_deinterleaver_top.sv */
// ----------------------------------------------------------------------------
// icy_metadata_deinterleaver_top
// Splits an ICY stream into audio, length and metadata bytes, and flags at
// the end of each metadata block whether its content changed.
// ----------------------------------------------------------------------------
// Usage:
//   One stream byte enters per in_ transfer. Every byte leaves again on the
//   out_ channel with its kind in out_tuser; out_tlast marks the last byte
//   of a metadata block or a zero length byte, and out_tuser[2] then says
//   whether the block differed from the stored metadata.
//   meta_interval is set over the APB port while the stream is idle; zero
//   passes everything through as audio.
//   A byte transferred in is held in the compare stage and then in the
//   output register, which drives the out_ channel. Throughput is one
//   byte per cycle while the receiver takes results: each metadata byte
//   does a read in the cycle it enters and a compare and write as it
//   leaves the compare stage, on the store's separate read and write ports.
//   A result waiting on a stalled receiver sits in the output register while
//   one more byte is held in the compare stage; in_tready drops only when
//   both are full.
//   Reset empties the pipeline, clears the interval and marks the whole
//   store as zero at once through a fill mark; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module icy_metadata_deinterleaver_top
  import icy_deint_pkg::*;
#(
  parameter int META_STORE_BYTES = META_STORE_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input stream. tdata: [7:0] data_in.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [BYTE_W-1:0]     in_tdata,
  // Result stream. tdata: [7:0] out_byte.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [BYTE_W-1:0]          out_tdata,
  // tuser: [1:0] byte_kind, [2] meta_changed.
  output logic [2:0]                 out_tuser,
  output logic                       out_tlast,
  // Configuration port.
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  localparam int AW = $clog2(META_STORE_BYTES);
  localparam int FW = $clog2(META_STORE_BYTES + 1);
  localparam int CW = IDX_W + 1;

  logic [CNT_W-1:0]  meta_interval_r;
  logic              accept;
  cls_t              cls;

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic [KIND_W-1:0] s1_kind_r;
  logic              s1_end_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic              s1_store_r;
  logic              s1_known_r;
  logic              s1_adv;

  logic [FW-1:0]     fill_r;
  logic              differs_r;
  logic [BYTE_W-1:0] ram_rdata;
  logic [BYTE_W-1:0] old_byte;
  logic              diff;
  logic              ram_wr;
  logic              changed;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [KIND_W-1:0] out_kind_r;
  logic              out_end_r;
  logic              out_changed_r;

  // Configuration register write and read back.
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_interval_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_META_INTERVAL) begin
      meta_interval_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_META_INTERVAL) begin
      cfg_prdata = CFG_DATA_W'(meta_interval_r);
    end
  end

  // Handshake: the compare stage moves on when the output register is free.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign accept    = in_tvalid && in_tready;

  // Byte classification.
  icy_deint_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data          (in_tdata),
    .meta_interval (meta_interval_r),
    .cls           (cls)
  );

  // Compare stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r  <= in_tdata;
      s1_kind_r  <= cls.kind;
      s1_end_r   <= cls.blk_end;
      s1_idx_r   <= cls.idx;
      s1_store_r <= CW'(cls.idx) < CW'(META_STORE_BYTES);
      s1_known_r <= CW'(cls.idx) < CW'(fill_r);
    end
  end

  // Metadata store: read on entry, compare and write as the byte leaves the compare stage.
  assign ram_wr = s1_adv && s1_kind_r == KIND_META && s1_store_r;

  icy_deint_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (META_STORE_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (s1_idx_r[AW-1:0]),
    .wr_data (s1_byte_r),
    .rd_en   (accept),
    .rd_addr (cls.idx[AW-1:0]),
    .rd_data (ram_rdata)
  );

  // Entries at or past the fill mark were never written and read as zero.
  assign old_byte = s1_known_r ? ram_rdata : '0;
  assign diff     = s1_kind_r == KIND_META && s1_store_r && old_byte != s1_byte_r;
  assign changed  = s1_kind_r == KIND_META && s1_end_r && (differs_r || diff);

  // Blocks always fill the store upward from the start, so one mark suffices.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (ram_wr && CW'(s1_idx_r) >= CW'(fill_r)) begin
      fill_r <= FW'(CW'(s1_idx_r) + CW'(1));
    end
  end

  // Change tracking across one block.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      differs_r <= 1'b0;
    end else if (s1_adv) begin
      case (s1_kind_r)
        KIND_META: differs_r <= s1_end_r ? 1'b0 : (differs_r || diff);
        KIND_LEN:  differs_r <= 1'b0;
        default:   differs_r <= differs_r;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_byte_r    <= s1_byte_r;
      out_kind_r    <= s1_kind_r;
      out_end_r     <= s1_end_r;
      out_changed_r <= changed;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_changed_r, out_kind_r};
  assign out_tlast  = out_end_r;

endmodule

`default_nettype wire
